// ----- rtl/core/dvru_pkg.sv -----
// Shared types and constants for the distance-vector route update block.
// No dependencies; every other file of the block refers to this package.
package dvru_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int ADDR_W          = 32;
    localparam int ADV_METRIC_W    = 5;
    localparam int HOP_METRIC_W    = ADV_METRIC_W + 1;
    localparam int STORED_METRIC_W = 4;
    localparam int PORT_W          = 3;
    localparam int OUTCOME_W       = 3;
    localparam int SLOT_W          = 4;

    // A metric of this value or more means the route is unreachable.
    localparam logic [HOP_METRIC_W-1:0] UNREACHABLE = HOP_METRIC_W'(16);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_DISABLED  = 3'd0,
        OUT_ADDED     = 3'd1,
        OUT_DROPPED   = 3'd2,
        OUT_DELETED   = 3'd3,
        OUT_REPLACED  = 3'd4,
        OUT_REFRESHED = 3'd5,
        OUT_WORSE     = 3'd6,
        OUT_FULL      = 3'd7
    } t_outcome;

    typedef struct packed {
        logic [ADDR_W-1:0]       dest_addr;
        logic [ADDR_W-1:0]       dest_mask;
        logic [ADV_METRIC_W-1:0] adv_metric;
        logic [ADDR_W-1:0]       neighbour_addr;
        logic [PORT_W-1:0]       arrival_port;
    } t_adv;

    typedef struct packed {
        logic [ADDR_W-1:0]          dest;
        logic [ADDR_W-1:0]          mask;
        logic [STORED_METRIC_W-1:0] metric;
        logic [ADDR_W-1:0]          gateway;
        logic [PORT_W-1:0]          port;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch the accepted advertisement, rewind the scan
        logic scan;    // read the next table entry
        logic commit;  // apply the decision and register the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enable;   // configuration register
        logic rd_last;  // the scan is reading the last table entry
    } t_status;

endpackage

// ----- rtl/core/dvru_if.sv -----
// Channel interfaces of the distance-vector route update block: the
// advertisement input, the result output and the configuration write port.
// Depends on dvru_pkg for field widths.
interface dvru_adv_if;
    logic                               valid;
    logic                               ready;
    logic [dvru_pkg::ADDR_W-1:0]        dest_addr;
    logic [dvru_pkg::ADDR_W-1:0]        dest_mask;
    logic [dvru_pkg::ADV_METRIC_W-1:0]  adv_metric;
    logic [dvru_pkg::ADDR_W-1:0]        neighbour_addr;
    logic [dvru_pkg::PORT_W-1:0]        arrival_port;

    modport source (
        output valid, dest_addr, dest_mask, adv_metric, neighbour_addr, arrival_port,
        input  ready
    );
    modport sink (
        input  valid, dest_addr, dest_mask, adv_metric, neighbour_addr, arrival_port,
        output ready
    );
endinterface

interface dvru_res_if;
    logic                            valid;
    logic                            ready;
    logic [dvru_pkg::OUTCOME_W-1:0]  outcome;
    logic [dvru_pkg::SLOT_W-1:0]     slot;

    modport source (output valid, outcome, slot, input ready);
    modport sink (input valid, outcome, slot, output ready);
endinterface

interface dvru_cfg_if;
    logic valid;
    logic ready;
    logic enable;

    modport source (output valid, enable, input ready);
    modport sink (input valid, enable, output ready);
endinterface

// ----- rtl/core/dvru_ctrl.sv -----
// Sequencing controller of the distance-vector route update block.
// Depends on dvru_pkg for the command and status structs.
module dvru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv_valid,
    output logic              o_adv_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  dvru_pkg::t_status i_sts,
    output dvru_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DECIDE,
        ST_HOLD
    } t_state;

    t_state r_state;
    logic   r_adv_ready;
    logic   r_res_valid;
    logic   w_accept;

    assign w_accept = (r_state == ST_IDLE) && i_adv_valid && r_adv_ready;

    always_comb begin
        o_cmd.start  = w_accept;
        o_cmd.scan   = (r_state == ST_SCAN);
        o_cmd.commit = (r_state == ST_DECIDE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_adv_ready <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_adv_ready <= 1'b0;
                        // A disabled block skips the table scan entirely.
                        r_state     <= i_sts.enable ? ST_SCAN : ST_DECIDE;
                    end
                end
                ST_SCAN: begin
                    if (i_sts.rd_last) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_res_valid <= 1'b1;
                    r_state     <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (i_res_ready) begin
                        r_res_valid <= 1'b0;
                        r_adv_ready <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_adv_ready <= 1'b1;
                    r_res_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_adv_ready = r_adv_ready;
    assign o_res_valid = r_res_valid;

endmodule

// ----- rtl/core/dvru_dpath.sv -----
// Datapath of the distance-vector route update block: route memory, valid
// bits, scan compare, update decision and result registers. Uses dvru_pkg.
module dvru_dpath #(
    parameter int TABLE_ENTRIES = dvru_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dvru_pkg::t_cmd                  i_cmd,
    input  dvru_pkg::t_adv                  i_adv,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_enable,
    output logic                            o_cfg_ready,
    output dvru_pkg::t_status               o_sts,
    output logic [dvru_pkg::OUTCOME_W-1:0]  o_outcome,
    output logic [dvru_pkg::SLOT_W-1:0]     o_slot
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int EXT_W = (IDX_W > dvru_pkg::SLOT_W) ? IDX_W : dvru_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic                     r_enable;
    dvru_pkg::t_adv           r_item;
    logic [TABLE_ENTRIES-1:0] r_valid;
    dvru_pkg::t_entry         r_route_mem [TABLE_ENTRIES];

    logic [IDX_W-1:0]         r_rd_idx;
    dvru_pkg::t_entry         r_rd_data;
    logic                     r_cmp_vld;
    logic [IDX_W-1:0]         r_cmp_idx;

    logic                     r_hit_found;
    logic [IDX_W-1:0]         r_hit_idx;
    dvru_pkg::t_entry         r_hit_entry;
    logic                     r_free_found;
    logic [IDX_W-1:0]         r_free_idx;

    logic [dvru_pkg::OUTCOME_W-1:0] r_outcome;
    logic [dvru_pkg::SLOT_W-1:0]    r_slot;

    logic                                w_match;
    logic                                w_free;
    logic [dvru_pkg::HOP_METRIC_W-1:0]   w_metric;
    logic [dvru_pkg::HOP_METRIC_W-1:0]   w_old_metric;
    logic                                w_unreach;
    dvru_pkg::t_outcome                  w_outcome;
    logic [IDX_W-1:0]                    w_idx;
    logic                                w_report_idx;
    logic                                w_wr_en;
    dvru_pkg::t_entry                    w_wr_entry;
    logic                                w_set_valid;
    logic                                w_clr_valid;
    logic [EXT_W-1:0]                    w_slot_ext;

    // Configuration register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_enable <= i_cfg_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_adv;
        end
    end

    // Scan address and compare-stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_rd_idx <= '0;
            end else if (i_cmd.scan) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
        end
    end

    // Route memory: one read port for the scan, one write port for commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_data <= r_route_mem[r_rd_idx];
            r_cmp_idx <= r_rd_idx;
        end
        if (w_wr_en) begin
            r_route_mem[w_idx] <= w_wr_entry;
        end
    end

    assign w_match = r_valid[r_cmp_idx] && (r_rd_data.dest == r_item.dest_addr);
    assign w_free  = !r_valid[r_cmp_idx];

    // The first matching and the first free slot in scan order are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_cmp_vld) begin
            if (w_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
            end
            if (w_free && !r_free_found) begin
                r_free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_vld && w_match && !r_hit_found) begin
            r_hit_idx   <= r_cmp_idx;
            r_hit_entry <= r_rd_data;
        end
        if (r_cmp_vld && w_free && !r_free_found) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // Update decision, evaluated once the scan has finished.
    assign w_metric     = dvru_pkg::HOP_METRIC_W'(r_item.adv_metric) + dvru_pkg::HOP_METRIC_W'(1);
    assign w_old_metric = dvru_pkg::HOP_METRIC_W'(r_hit_entry.metric);
    assign w_unreach    = (w_metric >= dvru_pkg::UNREACHABLE);

    always_comb begin
        w_outcome    = dvru_pkg::OUT_DISABLED;
        w_idx        = r_hit_idx;
        w_report_idx = 1'b0;
        w_set_valid  = 1'b0;
        w_clr_valid  = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_entry.dest    = r_item.dest_addr;
        w_wr_entry.mask    = r_hit_entry.mask;
        w_wr_entry.metric  = w_metric[dvru_pkg::STORED_METRIC_W-1:0];
        w_wr_entry.gateway = r_item.neighbour_addr;
        w_wr_entry.port    = r_item.arrival_port;
        if (!r_enable) begin
            w_outcome = dvru_pkg::OUT_DISABLED;
        end else if (!r_hit_found) begin
            if (w_unreach) begin
                w_outcome = dvru_pkg::OUT_DROPPED;
            end else if (!r_free_found) begin
                w_outcome = dvru_pkg::OUT_FULL;
            end else begin
                w_outcome       = dvru_pkg::OUT_ADDED;
                w_idx           = r_free_idx;
                w_report_idx    = 1'b1;
                w_set_valid     = 1'b1;
                w_wr_en         = i_cmd.commit;
                w_wr_entry.mask = r_item.dest_mask;
            end
        end else begin
            w_report_idx = 1'b1;
            if (w_unreach) begin
                w_outcome   = dvru_pkg::OUT_DELETED;
                w_clr_valid = 1'b1;
            end else if ((w_old_metric > w_metric) ||
                         ((r_hit_entry.gateway == r_item.neighbour_addr) &&
                          (w_old_metric != w_metric))) begin
                w_outcome = dvru_pkg::OUT_REPLACED;
                w_wr_en   = i_cmd.commit;
            end else if (w_old_metric == w_metric) begin
                w_outcome = dvru_pkg::OUT_REFRESHED;
            end else begin
                w_outcome = dvru_pkg::OUT_WORSE;
            end
        end
    end

    assign w_slot_ext = EXT_W'(w_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (w_set_valid) begin
                r_valid[w_idx] <= 1'b1;
            end else if (w_clr_valid) begin
                r_valid[w_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_outcome <= w_outcome;
            r_slot    <= w_report_idx ? w_slot_ext[dvru_pkg::SLOT_W-1:0] : '0;
        end
    end

    always_comb begin
        o_sts.enable  = r_enable;
        o_sts.rd_last = (r_rd_idx == LAST_IDX);
    end

    assign o_outcome = r_outcome;
    assign o_slot    = r_slot;

endmodule

// ----- rtl/core/distance_vector_route_update.sv -----
// Top level of the distance-vector route update block: joins the channel
// interfaces to the controller and the datapath. Uses dvru_pkg and dvru_if.
//
// Each advertisement beat carries a destination, mask, advertised metric,
// neighbour address and arrival port. The block adds one hop to the metric
// (16 or more is unreachable) and applies it to a route table matched on
// destination alone, lowest matching slot first. Exactly one result beat
// follows each advertisement beat, giving the outcome code and the slot that
// matched or was written (slot is 0 for disabled, dropped and table-full
// outcomes, and reported modulo 16 for larger tables). One advertisement is
// handled at a time: a new one is not accepted until the result beat has
// been taken. After acceptance the controller passes through its scan, flush
// and decide states before the result beat becomes valid. The scan reads
// the route memory one entry per cycle through its single read port while
// the compare stage looks for the first matching and the first free slot.
// While the block is disabled the scan is skipped and the controller goes
// from acceptance straight to its decide state. Valid bits live in
// flip-flops and are cleared at reset, so there is no clearing pass after
// reset. The configuration write port is always ready and should only be
// written while no advertisement is in flight.
module distance_vector_route_update #(
    parameter int TABLE_ENTRIES = dvru_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dvru_adv_if.sink    i_adv,
    dvru_res_if.source  o_res,
    dvru_cfg_if.sink    i_cfg
);

    dvru_pkg::t_cmd     w_cmd;
    dvru_pkg::t_status  w_sts;
    dvru_pkg::t_adv     w_adv;
    logic               w_adv_ready;
    logic               w_res_valid;
    logic               w_cfg_ready;
    logic [dvru_pkg::OUTCOME_W-1:0] w_outcome;
    logic [dvru_pkg::SLOT_W-1:0]    w_slot;

    // Gather the advertisement beat into one payload word.
    always_comb begin
        w_adv.dest_addr      = i_adv.dest_addr;
        w_adv.dest_mask      = i_adv.dest_mask;
        w_adv.adv_metric     = i_adv.adv_metric;
        w_adv.neighbour_addr = i_adv.neighbour_addr;
        w_adv.arrival_port   = i_adv.arrival_port;
    end

    dvru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv_valid (i_adv.valid),
        .o_adv_ready (w_adv_ready),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dvru_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_adv        (w_adv),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_enable (i_cfg.enable),
        .o_cfg_ready  (w_cfg_ready),
        .o_sts        (w_sts),
        .o_outcome    (w_outcome),
        .o_slot       (w_slot)
    );

    assign i_adv.ready   = w_adv_ready;
    assign i_cfg.ready   = w_cfg_ready;
    assign o_res.valid   = w_res_valid;
    assign o_res.outcome = w_outcome;
    assign o_res.slot    = w_slot;

endmodule
